// ===== sv/rtc_pkg.sv =====
// Package for the route transposition cipher block.
// Holds the default block dimensions, the register map and the padding constant.
package rtc_pkg;

  localparam int unsigned MAX_ROWS_DEF = 8;
  localparam int unsigned MAX_COLS_DEF = 8;

  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'd1;

  localparam logic [CFG_DATA_W-1:0] DIM_RESET = 4'd8;
  localparam logic [CHAR_W-1:0]     PAD_FIRST = 8'h61;

endpackage

// ===== sv/rtc_if.sv =====
// Handshake channels of the route transposition cipher block.
// Depends on rtc_pkg for the byte width.
interface rtc_in_if import rtc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [CHAR_W-1:0] char_in;

  modport source (output valid, output mode, output char_in, input ready);
  modport sink   (input valid, input mode, input char_in, output ready);
endinterface

interface rtc_out_if import rtc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_out;
  logic              block_end;
  logic              message_end;

  modport source (output valid, output char_out, output block_end, output message_end,
                  input ready);
  modport sink   (input valid, input char_out, input block_end, input message_end,
                  output ready);
endinterface

// ===== sv/rtc_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies; contents are undefined until written.
module rtc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/route_transposition_cipher.sv =====
// Route transposition cipher: bytes are stored row by row and sent column by column.
// After a block's last byte (or its flush and its padding) its bytes are read through
// the registered RAM port into an output register, one a cycle while out_o.ready holds.
// Input is taken one byte a cycle while a block fills; it is held off during padding
// and while the block's reads are issued. Reset empties the block and sets both
// dimensions to eight; the store itself is not cleared.
module route_transposition_cipher import rtc_pkg::*; #(
  parameter int unsigned MaxRows = MAX_ROWS_DEF,
  parameter int unsigned MaxCols = MAX_COLS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  rtc_in_if.sink                in_i,
  rtc_out_if.source             out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned Depth = MaxRows * MaxCols;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW    = $clog2(Depth + 1);
  localparam int unsigned RW    = $clog2(MaxRows + 1);
  localparam int unsigned LW    = $clog2(MaxCols + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PAD  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [CFG_DATA_W-1:0] rows_q, cols_q;
  logic [CW-1:0]         fill_q, fill_d;
  logic [CHAR_W-1:0]     pad_q, pad_d;
  logic                  msg_q, msg_d;
  logic [RW-1:0]         ri_q, ri_d;
  logic [LW-1:0]         ci_q, ci_d;
  logic [AW-1:0]         addr_q, addr_d;
  logic                  a_vld_q, a_last_q, a_msg_q;
  logic                  out_vld_q, out_last_q, out_msg_q;
  logic [CHAR_W-1:0]     out_char_q;

  logic [RW-1:0]     r_dim;
  logic [LW-1:0]     c_dim;
  logic [CW-1:0]     total;
  logic [CW-1:0]     fill_nx;
  logic              accept, mv, issue, last_rd;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [CHAR_W-1:0] wdata;
  logic [CHAR_W-1:0] rdata;

  always_comb begin
    if (rows_q == '0) begin
      r_dim = RW'(1);
    end else if (int'(rows_q) > int'(MaxRows)) begin
      r_dim = RW'(MaxRows);
    end else begin
      r_dim = RW'(rows_q);
    end
    if (cols_q == '0) begin
      c_dim = LW'(1);
    end else if (int'(cols_q) > int'(MaxCols)) begin
      c_dim = LW'(MaxCols);
    end else begin
      c_dim = LW'(cols_q);
    end
  end

  assign total = CW'(CW'(r_dim) * CW'(c_dim));

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign mv         = a_vld_q && (!out_vld_q || out_o.ready);
  assign issue      = (state_q == ST_EMIT) && (!a_vld_q || mv);
  assign last_rd    = (ci_q == LW'(c_dim - LW'(1))) && (ri_q == RW'(r_dim - RW'(1)));
  assign fill_nx    = (fill_q < total) ? CW'(fill_q + CW'(1)) : fill_q;

  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    pad_d   = pad_q;
    msg_d   = msg_q;
    ri_d    = ri_q;
    ci_d    = ci_q;
    addr_d  = addr_q;
    we      = 1'b0;
    waddr   = fill_q[AW-1:0];
    wdata   = in_i.char_in;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          ri_d   = '0;
          ci_d   = '0;
          addr_d = '0;
          if (!in_i.mode) begin
            we     = (fill_q < total);
            fill_d = fill_nx;
            msg_d  = 1'b0;
            if (fill_nx >= total) begin
              state_d = ST_EMIT;
            end
          end else if (fill_q != '0) begin
            msg_d = 1'b1;
            pad_d = PAD_FIRST;
            if (fill_q < total) begin
              state_d = ST_PAD;
            end else begin
              state_d = ST_EMIT;
            end
          end
        end
      end
      ST_PAD: begin
        we     = 1'b1;
        wdata  = pad_q;
        fill_d = CW'(fill_q + CW'(1));
        pad_d  = CHAR_W'(pad_q + CHAR_W'(1));
        if (CW'(fill_q + CW'(1)) >= total) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (issue) begin
          if (last_rd) begin
            state_d = ST_IDLE;
            fill_d  = '0;
          end else if (ri_q == RW'(r_dim - RW'(1))) begin
            ri_d   = '0;
            ci_d   = LW'(ci_q + LW'(1));
            addr_d = AW'(CW'(ci_q) + CW'(1));
          end else begin
            ri_d   = RW'(ri_q + RW'(1));
            addr_d = AW'(CW'(addr_q) + CW'(c_dim));
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  rtc_ram #(
    .Width (CHAR_W),
    .Depth (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (issue),
    .raddr_i (addr_q),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      rows_q    <= DIM_RESET;
      cols_q    <= DIM_RESET;
      fill_q    <= '0;
      pad_q     <= PAD_FIRST;
      msg_q     <= 1'b0;
      ri_q      <= '0;
      ci_q      <= '0;
      addr_q    <= '0;
      a_vld_q   <= 1'b0;
      a_last_q  <= 1'b0;
      a_msg_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      pad_q   <= pad_d;
      msg_q   <= msg_d;
      ri_q    <= ri_d;
      ci_q    <= ci_d;
      addr_q  <= addr_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_ROWS: rows_q <= cfg_data_i;
          CFG_COLS: cols_q <= cfg_data_i;
          default:  ;
        endcase
      end
      if (issue) begin
        a_vld_q  <= 1'b1;
        a_last_q <= last_rd;
        a_msg_q  <= last_rd && msg_q;
      end else if (mv) begin
        a_vld_q <= 1'b0;
      end
      if (mv) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mv) begin
      out_char_q <= rdata;
      out_last_q <= a_last_q;
      out_msg_q  <= a_msg_q;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.char_out    = out_char_q;
  assign out_o.block_end   = out_last_q;
  assign out_o.message_end = out_msg_q;

endmodule
